[rtl/mer_pkg.sv]
// mer_pkg: shared types and codes for the midpoint ellipse rasterizer
// no dependencies; imported by the controller, datapath, top level and checker
package mer_pkg;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_STEP  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_M_RX,
        S_M_RY,
        S_M_SY,
        S_INIT,
        S_CHECK,
        S_UPD,
        S_M_HX,
        S_M_YM,
        S_M_D1,
        S_M_D2,
        S_M_D3,
        S_M_D4
    } t_state;

    // operand pairs for the shared multiplier
    typedef enum logic [2:0] {
        MUL_RX_RX,
        MUL_RY_RY,
        MUL_RX2_RY,
        MUL_HX_HX,
        MUL_YM_YM,
        MUL_TMP_RY2,
        MUL_TMP_RX2,
        MUL_RX2_RY2
    } t_mul_sel;

    // what the datapath does with the registered product
    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_RX2,
        ACT_RY2,
        ACT_INIT,
        ACT_DEC_UPD,
        ACT_TMP,
        ACT_D_SET,
        ACT_D_ADD,
        ACT_D_SUB
    } t_act;

    typedef struct packed {
        logic     load;
        logic     step;
        t_mul_sel mul_sel;
        t_act     act;
    } t_cmd;

    typedef struct packed {
        logic active;
        logic fin;
        logic to_region_two;
        logic out_valid;
    } t_status;

endpackage

[rtl/mer_ctrl.sv]
// mer_ctrl: sequencer for start set-up, decision updates and region-two set-up
// depends on mer_pkg for the state, command and status types
module mer_ctrl
    import mer_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_kind,
    input  logic    i_out_ready,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE) && (!i_status.out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_kind == KIND_START) begin
                        n_state = S_M_RX;
                    end else if (i_status.active && !i_status.fin) begin
                        n_state = S_UPD;
                    end
                end
            end
            S_M_RX:  n_state = S_M_RY;
            S_M_RY:  n_state = S_M_SY;
            S_M_SY:  n_state = S_INIT;
            S_INIT:  n_state = S_CHECK;
            S_CHECK: n_state = i_status.to_region_two ? S_M_HX : S_IDLE;
            S_UPD:   n_state = i_status.to_region_two ? S_M_HX : S_IDLE;
            S_M_HX:  n_state = S_M_YM;
            S_M_YM:  n_state = S_M_D1;
            S_M_D1:  n_state = S_M_D2;
            S_M_D2:  n_state = S_M_D3;
            S_M_D3:  n_state = S_M_D4;
            S_M_D4:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.load    = accept && (i_kind == KIND_START);
        o_cmd.step    = accept && (i_kind == KIND_STEP);
        o_cmd.mul_sel = MUL_RX_RX;
        o_cmd.act     = ACT_NONE;
        unique case (r_state)
            S_M_RX: o_cmd.mul_sel = MUL_RX_RX;
            S_M_RY: begin
                o_cmd.mul_sel = MUL_RY_RY;
                o_cmd.act     = ACT_RX2;
            end
            S_M_SY: begin
                o_cmd.mul_sel = MUL_RX2_RY;
                o_cmd.act     = ACT_RY2;
            end
            S_INIT: o_cmd.act = ACT_INIT;
            S_UPD:  o_cmd.act = ACT_DEC_UPD;
            S_M_HX: o_cmd.mul_sel = MUL_HX_HX;
            S_M_YM: begin
                o_cmd.mul_sel = MUL_YM_YM;
                o_cmd.act     = ACT_TMP;
            end
            S_M_D1: begin
                o_cmd.mul_sel = MUL_TMP_RY2;
                o_cmd.act     = ACT_TMP;
            end
            S_M_D2: begin
                o_cmd.mul_sel = MUL_TMP_RX2;
                o_cmd.act     = ACT_D_SET;
            end
            S_M_D3: begin
                o_cmd.mul_sel = MUL_RX2_RY2;
                o_cmd.act     = ACT_D_ADD;
            end
            S_M_D4: o_cmd.act = ACT_D_SUB;
            S_IDLE, S_CHECK: o_cmd.act = ACT_NONE;
            default: o_cmd.act = ACT_NONE;
        endcase
    end

endmodule

[rtl/mer_datapath.sv]
// mer_datapath: geometry, position, slope and decision registers, shared multiplier
// and the output register; depends on mer_pkg, driven by mer_ctrl commands
module mer_datapath
    import mer_pkg::*;
#(
    parameter int RADIUS_BITS = 10,
    parameter int COORD_BITS  = 13
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cmd                         i_cmd,
    output t_status                      o_status,
    input  logic [RADIUS_BITS-1:0]       i_radius_x,
    input  logic [RADIUS_BITS-1:0]       i_radius_y,
    input  logic [COORD_BITS-3:0]        i_center_x,
    input  logic [COORD_BITS-3:0]        i_center_y,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic signed [COORD_BITS-1:0] o_right_col,
    output logic signed [COORD_BITS-1:0] o_left_col,
    output logic signed [COORD_BITS-1:0] o_lower_row,
    output logic signed [COORD_BITS-1:0] o_upper_row,
    output logic                         o_last
);

    localparam int XY_W    = RADIUS_BITS + 1;
    localparam int SQ_W    = 2 * RADIUS_BITS;
    localparam int MA_W    = 2 * RADIUS_BITS + 4;
    localparam int PROD_W  = MA_W + SQ_W;
    localparam int SLOPE_W = 3 * RADIUS_BITS + 4;
    localparam int DEC_W   = 4 * RADIUS_BITS + 7;
    localparam int CEN_W   = COORD_BITS - 2;

    logic [RADIUS_BITS-1:0]      r_rx, r_ry;
    logic [CEN_W-1:0]            r_cx, r_cy;
    logic [SQ_W-1:0]             r_rx2, r_ry2;
    logic [XY_W-1:0]             r_x, r_y;
    logic signed [SLOPE_W-1:0]   r_sx, r_sy;
    logic signed [DEC_W-1:0]     r_dec;
    logic [MA_W-1:0]             r_tmp;
    logic [PROD_W-1:0]           r_prod;
    logic                        r_alt;
    logic                        r_active, r_region2, r_out_valid;
    logic signed [COORD_BITS-1:0] r_right, r_left, r_lower, r_upper;
    logic                        r_last;

    logic [MA_W-1:0]             mul_a;
    logic [SQ_W-1:0]             mul_b;
    logic [XY_W:0]               hx;
    logic [XY_W-1:0]             ym;
    logic signed [SLOPE_W-1:0]   two_rx2, two_ry2;
    logic signed [DEC_W-1:0]     prod_e, sx_e, sy_e, k_e, upd_term;
    logic                        dec_neg, dec_pos, fin, advance;
    logic [COORD_BITS-1:0]       x_c, y_c, cx_c, cy_c;

    assign hx      = {r_x, 1'b1};
    // (y - 1)^2 only needs the magnitude, which is one when y is zero
    assign ym      = (r_y == '0) ? XY_W'(1) : (r_y - XY_W'(1));
    assign two_rx2 = $signed(SLOPE_W'({r_rx2, 1'b0}));
    assign two_ry2 = $signed(SLOPE_W'({r_ry2, 1'b0}));
    assign prod_e  = $signed(DEC_W'(r_prod));
    assign dec_neg = r_dec[DEC_W-1];
    assign dec_pos = !dec_neg && (r_dec != '0);
    assign fin     = r_region2 && (r_y == '0);
    assign advance = i_cmd.step && r_active;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.mul_sel)
            MUL_RX_RX: begin
                mul_a = MA_W'(r_rx);
                mul_b = SQ_W'(r_rx);
            end
            MUL_RY_RY: begin
                mul_a = MA_W'(r_ry);
                mul_b = SQ_W'(r_ry);
            end
            MUL_RX2_RY: begin
                mul_a = MA_W'(r_rx2);
                mul_b = SQ_W'(r_ry);
            end
            MUL_HX_HX: begin
                mul_a = MA_W'(hx);
                mul_b = SQ_W'(hx);
            end
            MUL_YM_YM: begin
                mul_a = MA_W'(ym);
                mul_b = SQ_W'(ym);
            end
            MUL_TMP_RY2: begin
                mul_a = r_tmp;
                mul_b = r_ry2;
            end
            MUL_TMP_RX2: begin
                mul_a = r_tmp;
                mul_b = r_rx2;
            end
            MUL_RX2_RY2: begin
                mul_a = MA_W'(r_rx2);
                mul_b = r_ry2;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // quarter-scaled increment: region one adds the x slope always and removes the y
    // slope on a diagonal move, region two the other way round
    always_comb begin
        sx_e     = (r_alt || !r_region2) ? DEC_W'(r_sx) : '0;
        sy_e     = (r_alt || r_region2) ? DEC_W'(r_sy) : '0;
        k_e      = r_region2 ? $signed(DEC_W'(r_rx2)) : $signed(DEC_W'(r_ry2));
        upd_term = sx_e - sy_e + k_e;
    end

    assign x_c  = COORD_BITS'(r_x);
    assign y_c  = COORD_BITS'(r_y);
    assign cx_c = COORD_BITS'(r_cx);
    assign cy_c = COORD_BITS'(r_cy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_region2   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_active  <= 1'b1;
                r_region2 <= 1'b0;
            end else if (advance && fin) begin
                r_active <= 1'b0;
            end else if (i_cmd.act == ACT_D_SUB) begin
                r_region2 <= 1'b1;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(mul_a * mul_b);

        if (i_cmd.load) begin
            r_rx <= i_radius_x;
            r_ry <= i_radius_y;
            r_cx <= i_center_x;
            r_cy <= i_center_y;
            r_x  <= '0;
            r_y  <= XY_W'(i_radius_y);
            r_sx <= '0;
        end

        if (advance) begin
            r_right <= cx_c + x_c;
            r_left  <= cx_c - x_c;
            r_lower <= cy_c + y_c;
            r_upper <= cy_c - y_c;
            r_last  <= fin;
            if (!fin) begin
                if (!r_region2) begin
                    r_x   <= r_x + XY_W'(1);
                    r_sx  <= r_sx + two_ry2;
                    r_alt <= !dec_neg;
                    if (!dec_neg) begin
                        r_y  <= r_y - XY_W'(1);
                        r_sy <= r_sy - two_rx2;
                    end
                end else begin
                    r_y   <= r_y - XY_W'(1);
                    r_sy  <= r_sy - two_rx2;
                    r_alt <= !dec_pos;
                    if (!dec_pos) begin
                        r_x  <= r_x + XY_W'(1);
                        r_sx <= r_sx + two_ry2;
                    end
                end
            end
        end

        case (i_cmd.act)
            ACT_RX2: r_rx2 <= SQ_W'(r_prod);
            ACT_RY2: r_ry2 <= SQ_W'(r_prod);
            ACT_INIT: begin
                r_sy  <= $signed(SLOPE_W'({r_prod, 1'b0}));
                r_dec <= ($signed(DEC_W'(r_ry2)) <<< 2) - (prod_e <<< 2)
                         + $signed(DEC_W'(r_rx2));
            end
            ACT_DEC_UPD: r_dec <= r_dec + (upd_term <<< 2);
            ACT_TMP:     r_tmp <= MA_W'(r_prod);
            ACT_D_SET:   r_dec <= prod_e;
            ACT_D_ADD:   r_dec <= r_dec + (prod_e <<< 2);
            ACT_D_SUB:   r_dec <= r_dec - (prod_e <<< 2);
            default:     r_dec <= r_dec;
        endcase
    end

    assign o_status.active        = r_active;
    assign o_status.fin           = fin;
    assign o_status.to_region_two = !r_region2 && (r_sx >= r_sy);
    assign o_status.out_valid     = r_out_valid;

    assign o_out_valid = r_out_valid;
    assign o_right_col = r_right;
    assign o_left_col  = r_left;
    assign o_lower_row = r_lower;
    assign o_upper_row = r_upper;
    assign o_last      = r_last;

endmodule

[rtl/midpoint_ellipse_rasterizer_unit.sv]
// channel | valid      | ready       | payload
// input   | i_in_valid | o_in_ready  | i_kind, i_radius_x/y, i_center_x/y
// output  | o_out_valid| i_out_ready | o_right_col, o_left_col, o_lower_row, o_upper_row, o_last
//
// in a step, the transaction cycle emits the point set and moves x/y and the
// slopes, the next cycle updates the decision; a step that enters region two then forms
// the five region-two products through the single shared multiplier
// a start forms three products for squares and slope, then runs set-up and check, and
// also the region-two set-up on a zero radius; an idle or final step leaves the sequencer idle
// synchronous active-low reset leaves the block idle with no ellipse loaded
// o_in_ready needs the sequencer idle and the output register empty or being taken
// depends on mer_pkg, mer_ctrl and mer_datapath
module midpoint_ellipse_rasterizer_unit
    import mer_pkg::*;
#(
    parameter int RADIUS_BITS = 10,
    parameter int COORD_BITS  = 13
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_kind,
    input  logic [RADIUS_BITS-1:0]       i_radius_x,
    input  logic [RADIUS_BITS-1:0]       i_radius_y,
    input  logic [COORD_BITS-3:0]        i_center_x,
    input  logic [COORD_BITS-3:0]        i_center_y,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [COORD_BITS-1:0] o_right_col,
    output logic signed [COORD_BITS-1:0] o_left_col,
    output logic signed [COORD_BITS-1:0] o_lower_row,
    output logic signed [COORD_BITS-1:0] o_upper_row,
    output logic                         o_last
);

    t_cmd    cmd;
    t_status status;

    mer_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_kind      (i_kind),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_in_ready  (o_in_ready),
        .o_cmd       (cmd)
    );

    mer_datapath #(
        .RADIUS_BITS (RADIUS_BITS),
        .COORD_BITS  (COORD_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_radius_x  (i_radius_x),
        .i_radius_y  (i_radius_y),
        .i_center_x  (i_center_x),
        .i_center_y  (i_center_y),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_right_col (o_right_col),
        .o_left_col  (o_left_col),
        .o_lower_row (o_lower_row),
        .o_upper_row (o_upper_row),
        .o_last      (o_last)
    );

endmodule

[rtl/mer_checker.sv]
// mer_checker: port-level checks on the rasterizer handshakes and sequencing
// depends on mer_pkg; bound to midpoint_ellipse_rasterizer_unit below
module mer_checker
    import mer_pkg::*;
#(
    parameter int COORD_BITS  = 13
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_ready,
    input logic                         i_kind,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic signed [COORD_BITS-1:0] o_right_col,
    input logic signed [COORD_BITS-1:0] o_left_col,
    input logic signed [COORD_BITS-1:0] o_lower_row,
    input logic signed [COORD_BITS-1:0] o_upper_row,
    input logic                         o_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable({o_right_col, o_left_col, o_lower_row, o_upper_row, o_last}))
        else $error("result changed while stalled");

    // a start always runs the set-up sequence, so the input side closes
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_kind == KIND_START) |=> !o_in_ready)
        else $error("input accepted during start set-up");

    // a new result only ever follows a step transaction
    a_out_from_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready && (i_kind == KIND_STEP)))
        else $error("result without a step");

endmodule

bind midpoint_ellipse_rasterizer_unit mer_checker #(
    .COORD_BITS  (COORD_BITS)
) u_mer_checker (.*);
